FILE: src/text_word_pretokenizer_assert.svh
// Assertion macros shared by the pretokenizer modules.
`ifndef TEXT_WORD_PRETOKENIZER_ASSERT_SVH
`define TEXT_WORD_PRETOKENIZER_ASSERT_SVH

// Check a property on every rising edge, skipped while reset is high.
`define TWP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define TWP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/ptok_pkg.sv
// Types and character constants for the text word pretokenizer.
`timescale 1ns / 1ps

package ptok_pkg;

   localparam int MAX_ITEMS = 3;   // most results one input word can cause
   localparam int Q_DEPTH   = 4;   // result slots
   localparam int Q_IDX_W   = 2;   // bits to index a result slot
   localparam int Q_CNT_W   = 3;   // bits to hold a slot count up to Q_DEPTH

   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_DIG_0 = 8'h30;
   localparam logic [7:0] CH_DIG_9 = 8'h39;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_V     = 8'h76;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_APOS = 2'd1,
      HELD_PAIR = 2'd2
   } held_type;

   typedef enum logic [1:0] {
      CLS_NONE    = 2'd0,
      CLS_LETTERS = 2'd1,
      CLS_OTHER   = 2'd2
   } cls_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } ptok_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       word_start;
      logic       text_done;
   } ptok_rsp_type;

   typedef struct packed {
      ptok_rsp_type [MAX_ITEMS-1:0] items;
      logic [1:0]                   count;
   } ptok_batch_type;

endpackage

FILE: src/ptok_step.sv
// Word split state and per-word decode into up to three results.
`timescale 1ns / 1ps
`include "text_word_pretokenizer_assert.svh"

module ptok_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ptok_pkg::ptok_req_type req_data,
   output ptok_pkg::ptok_batch_type batch
);
   import ptok_pkg::*;

   held_type   held_ff, held_in;
   cls_type    cls_ff, cls_in;
   logic [7:0] letter_ff, letter_in;

   logic [7:0]   c_low;
   logic         handled;
   logic         pair_match;
   logic [1:0]   n;
   ptok_rsp_type [MAX_ITEMS-1:0] items;

   always_comb begin
      c_low = req_data.text_byte;
      if (req_data.text_byte >= CH_UP_A && req_data.text_byte <= CH_UP_Z) begin
         c_low = req_data.text_byte | CASE_BIT;
      end
   end

   assign pair_match = (letter_ff == CH_R && c_low == CH_E) ||
                       (letter_ff == CH_V && c_low == CH_E) ||
                       (letter_ff == CH_L && c_low == CH_L);

   always_comb begin
      items     = '0;
      n         = 2'd0;
      handled   = 1'b0;
      held_in   = HELD_NONE;
      cls_in    = cls_ff;
      letter_in = letter_ff;

      // resolve a held apostrophe first
      case (held_ff)
         HELD_APOS: begin
            if (c_low == CH_S || c_low == CH_T || c_low == CH_M || c_low == CH_D) begin
               items[n] = '{out_byte: CH_APOS, has_byte: 1'b1, word_start: 1'b1,
                            text_done: 1'b0};
               n = n + 2'd1;
               items[n] = '{out_byte: c_low, has_byte: 1'b1, word_start: 1'b0,
                            text_done: 1'b0};
               n = n + 2'd1;
               cls_in  = CLS_NONE;
               handled = 1'b1;
            end else if (c_low == CH_R || c_low == CH_V || c_low == CH_L) begin
               letter_in = c_low;
               held_in   = HELD_PAIR;
               handled   = 1'b1;
            end else begin
               items[n] = '{out_byte: CH_APOS, has_byte: 1'b1, word_start: 1'b1,
                            text_done: 1'b0};
               n = n + 2'd1;
               cls_in = CLS_OTHER;
            end
         end
         HELD_PAIR: begin
            items[n] = '{out_byte: CH_APOS, has_byte: 1'b1, word_start: 1'b1,
                         text_done: 1'b0};
            n = n + 2'd1;
            if (pair_match) begin
               items[n] = '{out_byte: letter_ff, has_byte: 1'b1, word_start: 1'b0,
                            text_done: 1'b0};
               n = n + 2'd1;
               items[n] = '{out_byte: c_low, has_byte: 1'b1, word_start: 1'b0,
                            text_done: 1'b0};
               n = n + 2'd1;
               cls_in  = CLS_NONE;
               handled = 1'b1;
            end else begin
               items[n] = '{out_byte: letter_ff, has_byte: 1'b1, word_start: 1'b1,
                            text_done: 1'b0};
               n = n + 2'd1;
               cls_in = CLS_LETTERS;
            end
         end
         default: begin
         end
      endcase

      // plain handling of the current byte
      if (!handled) begin
         if (c_low == CH_SPACE || c_low == CH_TAB || c_low == CH_LF || c_low == CH_CR) begin
            cls_in = CLS_NONE;
         end else if (c_low >= CH_LO_A && c_low <= CH_LO_Z) begin
            items[n] = '{out_byte: c_low, has_byte: 1'b1,
                         word_start: (cls_in != CLS_LETTERS), text_done: 1'b0};
            n = n + 2'd1;
            cls_in = CLS_LETTERS;
         end else if (c_low >= CH_DIG_0 && c_low <= CH_DIG_9) begin
            items[n] = '{out_byte: c_low, has_byte: 1'b1, word_start: 1'b1,
                         text_done: 1'b0};
            n = n + 2'd1;
            cls_in = CLS_NONE;
         end else if (c_low == CH_APOS && cls_in != CLS_OTHER) begin
            held_in = HELD_APOS;
         end else begin
            items[n] = '{out_byte: c_low, has_byte: 1'b1,
                         word_start: (cls_in != CLS_OTHER), text_done: 1'b0};
            n = n + 2'd1;
            cls_in = CLS_OTHER;
         end
      end

      // end of text: flush held bytes, mark the last result, return to reset
      if (req_data.end_of_text) begin
         if (held_in != HELD_NONE) begin
            items[n] = '{out_byte: CH_APOS, has_byte: 1'b1, word_start: 1'b1,
                         text_done: 1'b0};
            n = n + 2'd1;
         end
         if (held_in == HELD_PAIR) begin
            items[n] = '{out_byte: letter_in, has_byte: 1'b1, word_start: 1'b1,
                         text_done: 1'b0};
            n = n + 2'd1;
         end
         if (n == 2'd0) begin
            items[n] = '{out_byte: 8'h00, has_byte: 1'b0, word_start: 1'b0,
                         text_done: 1'b0};
            n = n + 2'd1;
         end
         items[n - 2'd1].text_done = 1'b1;
         held_in   = HELD_NONE;
         cls_in    = CLS_NONE;
         letter_in = 8'h00;
      end
   end

   assign batch.items = items;
   assign batch.count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
         cls_ff  <= CLS_NONE;
      end else if (load) begin
         held_ff <= held_in;
         cls_ff  <= cls_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         letter_ff <= letter_in;
      end
   end

   `TWP_ASSERT(a_pair_letter, clock, reset,
      held_ff == HELD_PAIR |-> (letter_ff == CH_R || letter_ff == CH_V || letter_ff == CH_L),
      "held pair without r, v or l")
   `TWP_ASSERT(a_eot_clears, clock, reset,
      load && req_data.end_of_text |=> held_ff == HELD_NONE && cls_ff == CLS_NONE,
      "state not cleared after end of text")
   `TWP_ASSERT(a_eot_result, clock, reset,
      load && req_data.end_of_text |-> batch.count != 2'd0,
      "end of text produced no result")

endmodule

FILE: src/ptok_out_queue.sv
// Result slots: load a batch of results, drain one word per cycle while rsp_ready is high.
`timescale 1ns / 1ps
`include "text_word_pretokenizer_assert.svh"

module ptok_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  ptok_pkg::ptok_batch_type batch,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ptok_pkg::ptok_rsp_type   rsp_data
);
   import ptok_pkg::*;

   ptok_rsp_type slots_ff [Q_DEPTH];
   ptok_rsp_type slots_in [Q_DEPTH];
   ptok_rsp_type shifted  [Q_DEPTH];
   logic [Q_CNT_W-1:0] count_ff, count_in, count_sh;
   logic [Q_CNT_W-1:0] pos [MAX_ITEMS];
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slots_ff[0];
   assign pop       = rsp_valid & rsp_ready;
   assign can_load  = (count_ff <= Q_CNT_W'(1));
   assign count_sh  = count_ff - {{(Q_CNT_W-1){1'b0}}, pop};

   always_comb begin
      for (int k = 0; k < Q_DEPTH - 1; k++) begin
         shifted[k] = pop ? slots_ff[k+1] : slots_ff[k];
      end
      shifted[Q_DEPTH-1] = slots_ff[Q_DEPTH-1];

      slots_in = shifted;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         pos[i] = count_sh + Q_CNT_W'(i);
         if (load && 2'(i) < batch.count) begin
            slots_in[pos[i][Q_IDX_W-1:0]] = batch.items[i];
         end
      end

      count_in = load ? count_sh + {{(Q_CNT_W-2){1'b0}}, batch.count} : count_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   `TWP_ASSERT(a_count_bound, clock, reset,
      count_ff <= Q_CNT_W'(Q_DEPTH), "result slot count overflow")
   `TWP_ASSERT(a_load_room, clock, reset,
      load |-> count_ff <= Q_CNT_W'(1), "batch loaded without room")
   `TWP_ASSERT(a_pop_step, clock, reset,
      pop && !load |=> count_ff == $past(count_ff) - Q_CNT_W'(1),
      "drain did not advance by one word")

endmodule

FILE: src/text_word_pretokenizer.sv
// Top level of the text word pretokenizer.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+---------------------------------------------
//   req     | in  | req_valid/ready   | text_byte, end_of_text
//   rsp     | out | rsp_valid/ready   | out_byte, has_byte, word_start, text_done
//
// Each accepted text word is decoded in the same cycle into zero to three result
// words, which load a four-slot result register; results leave one per cycle while
// rsp_ready is high. A new text word is taken whenever at most one result is still
// waiting, so a stream that yields one result per byte runs at one word per cycle;
// a byte that completes a contraction or flush (up to three results) holds input
// until at most one result waits; the drain of the result slots sets this rate.
// Reset (synchronous, active high) drops held apostrophe bytes, closes any open
// word and empties the result slots. A stall on rsp keeps waiting results in place.
`timescale 1ns / 1ps

module text_word_pretokenizer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ptok_pkg::ptok_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptok_pkg::ptok_rsp_type rsp_data
);
   import ptok_pkg::*;

   ptok_batch_type batch;
   logic           can_load;
   logic           load;

   // take a text word only when the result slots have room for a full batch
   assign req_ready = can_load;
   assign load      = req_valid & can_load;

   // decode the word against the held apostrophe state
   ptok_step u_step (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .req_data (req_data),
      .batch    (batch)
   );

   // hold results and drain them one per cycle while rsp_ready is high
   ptok_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .batch     (batch),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
